>>> design/compacting_value_set_defines.svh
// ============================================================================
// Compacting value set assertion macros
// Shared macros for the concurrent checks on the value set ports.
// ============================================================================
`ifndef COMPACTING_VALUE_SET_DEFINES_SVH
`define COMPACTING_VALUE_SET_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cvs_pkg.sv
// ============================================================================
// Compacting value set package
// Command codes, the result record and the default capacity.
// ============================================================================
package cvs_pkg;

    localparam int CVS_CAPACITY = 16;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_DUMP     = 2'd3
    } cvs_cmd_t;

    typedef struct packed {
        logic               hit;
        logic               rejected;
        logic [4:0]         count;
        logic               empty_res;
        logic signed [31:0] element;
        logic               last;
    } cvs_result_t;

endpackage

>>> design/cvs_store.sv
// ============================================================================
// Compacting value set entry store
// Entry memory with one write port and one registered read port.
// ============================================================================
module cvs_store
    import cvs_pkg::*;
#(
    parameter int DEPTH = CVS_CAPACITY,
    parameter int AW    = 4
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/cvs_ctrl.sv
// ============================================================================
// Compacting value set sequencer
// Walks the store for search, compaction and dump, and builds each result.
// ============================================================================
module cvs_ctrl
    import cvs_pkg::*;
#(
    parameter int CAPACITY = CVS_CAPACITY,
    parameter int AW       = 4,
    parameter int CW       = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    input  logic                slot_free,
    output logic                res_push,
    output cvs_result_t         res,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic signed [31:0]  wr_data,
    output logic [AW-1:0]       rd_addr,
    input  logic signed [31:0]  rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_REPLY,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    state_t             state_reg,   state_next;
    cvs_cmd_t           cmd_reg,     cmd_next;
    logic signed [31:0] value_reg,   value_next;
    logic [CW-1:0]      count_reg,   count_next;
    logic [CW-1:0]      rd_idx_reg,  rd_idx_next;
    logic               cmp_v_reg,   cmp_v_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               hit_reg,     hit_next;
    logic               rej_reg,     rej_next;

    logic               issue;
    logic               match;
    logic               dump_last;
    logic [CW+4:0]      count_ext;

    // One read goes out per cycle while unread used entries remain; the
    // compare looks at the data of the read from the previous cycle.
    assign issue     = (rd_idx_reg < count_reg);
    assign match     = cmp_v_reg && (rd_data == value_reg);
    assign dump_last = (rd_idx_reg == (count_reg - CW'(1)));
    assign rd_addr   = rd_idx_reg[AW-1:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign count_ext = {5'b0, count_reg};

    always_comb
    begin
        res.hit       = hit_reg;
        res.rejected  = rej_reg;
        res.count     = count_ext[4:0];
        res.empty_res = (count_reg == '0);
        res.element   = (state_reg == S_DUMP_OUT) ? rd_data : 32'sd0;
        res.last      = (state_reg == S_DUMP_OUT) ? dump_last : 1'b1;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_v_next   = cmp_v_reg;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        rej_next     = rej_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = value_reg;
        res_push     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmp_v_next  = 1'b0;
                rd_idx_next = '0;
                if (in_valid)
                begin
                    cmd_next   = cvs_cmd_t'(cmd);
                    value_next = value;
                    hit_next   = 1'b0;
                    rej_next   = 1'b0;
                    if (cvs_cmd_t'(cmd) == CMD_DUMP)
                    begin
                        state_next = (count_reg == '0) ? S_REPLY : S_DUMP_RD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                cmp_v_next   = issue;
                cmp_idx_next = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                // The search ends on a match or once every used entry was
                // compared without one.
                if (match || (!cmp_v_reg && !issue))
                begin
                    hit_next   = match;
                    state_next = S_REPLY;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!match)
                            begin
                                if (count_reg < CW'(CAPACITY))
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    rej_next = 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (match)
                            begin
                                rd_idx_next = CW'(cmp_idx_reg) + CW'(1);
                                cmp_v_next  = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // Each entry above the hole is read, then written one slot down.
                cmp_v_next   = issue;
                cmp_idx_next = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (cmp_v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_idx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (!issue && !cmp_v_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_REPLY;
                end
            end

            S_REPLY:
            begin
                if (slot_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    res_push = 1'b1;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + CW'(1);
                        state_next  = S_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_v_reg   <= 1'b0;
            cmp_idx_reg <= '0;
            cmd_reg     <= CMD_ADD;
            value_reg   <= '0;
            hit_reg     <= 1'b0;
            rej_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_v_reg   <= cmp_v_next;
            cmp_idx_reg <= cmp_idx_next;
            cmd_reg     <= cmd_next;
            value_reg   <= value_next;
            hit_reg     <= hit_next;
            rej_reg     <= rej_next;
        end
    end

endmodule

>>> design/compacting_value_set.sv
// ============================================================================
// Compacting value set
// Fixed-capacity set of distinct signed 32-bit values kept packed in order.
// ============================================================================
//
//  Channel  Handshake            Payload
//  -------  -------------------  -----------------------------------------
//  in       in_valid / in_ready  cmd, value
//  out      out_valid/out_ready  hit, rejected, count, empty_res, element, last
//
// Each request is worked by a small sequencer over an entry memory with one
// write port and one registered read port. Add, remove and contains scan the
// used entries at one entry per cycle; a remove that hits then moves every
// later entry down, one per cycle. A dump reads each entry, then emits it
// as one result, and waits while the output register cannot take it.
// Reset clears the entry count but not the entry memory, which needs none.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register, so the next request can be taken while it waits;
// a stalled output holds the sequencer only when a new result is due.
//
module compacting_value_set
    import cvs_pkg::*;
#(
    parameter int CAPACITY = CVS_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic                rejected,
    output logic [4:0]          count,
    output logic                empty_res,
    output logic signed [31:0]  element,
    output logic                last
);

    // Address width of the entry memory and width of the fill count,
    // which has to reach CAPACITY itself.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               slot_free;
    logic               res_push;
    cvs_result_t        res;

    logic               out_valid_reg;
    cvs_result_t        out_res_reg;

    cvs_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cvs_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .slot_free (slot_free),
        .res_push  (res_push),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // The output register can take a new result when it is empty or when
    // its current result leaves in this cycle.
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_res_reg.hit;
    assign rejected  = out_res_reg.rejected;
    assign count     = out_res_reg.count;
    assign empty_res = out_res_reg.empty_res;
    assign element   = out_res_reg.element;
    assign last      = out_res_reg.last;

endmodule

>>> design/cvs_checker.sv
// ============================================================================
// Compacting value set port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ============================================================================
`include "compacting_value_set_defines.svh"

module cvs_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                hit,
    input logic                rejected,
    input logic [4:0]          count,
    input logic                empty_res,
    input logic signed [31:0]  element,
    input logic                last
);

    // The empty flag must agree with the reported count.
    `CVS_ASSERT_SAME(a_empty_count, clk, rst_n, out_valid, empty_res == (count == 5'd0), "empty_res disagrees with count")

    // A dropped add is only ever an add of a value that was absent.
    `CVS_ASSERT_SAME(a_reject_no_hit, clk, rst_n, out_valid && rejected, !hit && !empty_res, "rejected result with hit or empty set")

    // Only a dump gives results that are not last, and those carry no flags.
    `CVS_ASSERT_SAME(a_dump_flags, clk, rst_n, out_valid && !last, !hit && !rejected && !empty_res, "non-final result carries flags")

    // A request keeps the sequencer busy after accept, so ready drops.
    `CVS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while busy")

    // A stalled result holds.
    `CVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(element) && $stable(last) && $stable(count), "stalled result changed")

endmodule

bind compacting_value_set cvs_checker u_cvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .rejected  (rejected),
    .count     (count),
    .empty_res (empty_res),
    .element   (element),
    .last      (last)
);
